FILE: src/fan_speed_mode_controller_defines.svh
// ----------------------------------------------------------------------------
// Fan speed mode controller: assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_MODE_CONTROLLER_DEFINES_SVH
`define FAN_SPEED_MODE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define FSMC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fsmc check failed");
`define FSMC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fsmc check failed");
`else
`define FSMC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FSMC_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: src/fsmc_pkg.sv
// ----------------------------------------------------------------------------
// Fan speed mode controller package
// Shared types, codes, reset values and the thermal duty table.
// ----------------------------------------------------------------------------
package fsmc_pkg;

  typedef enum logic [1:0] {
    MODE_MANUAL  = 2'd0,
    MODE_RPM     = 2'd1,
    MODE_THERMAL = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_UP       = 3'd1,
    FUNC_DOWN     = 3'd2,
    FUNC_SET_RPM  = 3'd3,
    FUNC_SET_TEMP = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    CFG_CONTROL_MODE     = 3'd0,
    CFG_SMOOTH_ENABLE    = 3'd1,
    CFG_RPM_DEAD_BAND    = 3'd2,
    CFG_MANUAL_DUTY_STEP = 3'd3,
    CFG_RPM_TARGET_STEP  = 3'd4,
    CFG_TEMP_TARGET_STEP = 3'd5,
    CFG_RPM_TARGET_MAX   = 3'd6,
    CFG_TEMP_TARGET_MAX  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  control_mode;
    logic        smooth_enable;
    logic [15:0] rpm_dead_band;
    logic [6:0]  manual_duty_step;
    logic [15:0] rpm_target_step;
    logic [7:0]  temp_target_step;
    logic [15:0] rpm_target_max;
    logic [7:0]  temp_target_max;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         func;
    logic               power_on;
    logic [15:0]        rpm_measured;
    logic signed [8:0]  temp_measured;
    logic signed [16:0] set_value;
  } item_t;

  typedef struct packed {
    logic [6:0]        duty_percent;
    logic [15:0]       rpm_target_now;
    logic [7:0]        temp_target_now;
    logic signed [8:0] temp_smoothed;
    logic              stalled;
    logic              fan_active;
  } result_t;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_DATA_W  = 16;

  // register reset values
  localparam logic [15:0] RST_RPM_DEAD_BAND    = 16'd100;
  localparam logic [6:0]  RST_MANUAL_DUTY_STEP = 7'd5;
  localparam logic [15:0] RST_RPM_TARGET_STEP  = 16'd200;
  localparam logic [7:0]  RST_TEMP_TARGET_STEP = 8'd5;
  localparam logic [15:0] RST_RPM_TARGET_MAX   = 16'd5000;
  localparam logic [7:0]  RST_TEMP_TARGET_MAX  = 8'd80;

  // state reset values
  localparam logic [15:0] RST_RPM_GOAL  = 16'd2000;
  localparam logic [7:0]  RST_TEMP_GOAL = 8'd45;

  localparam logic [6:0] DUTY_MAX = 7'd100;

  // rpm error thresholds for the duty step size
  localparam logic [15:0] ERR_STEP5 = 16'd1500;
  localparam logic [15:0] ERR_STEP4 = 16'd1000;
  localparam logic [15:0] ERR_STEP3 = 16'd600;
  localparam logic [15:0] ERR_STEP2 = 16'd300;

  // divide by ten: (x * 3277) >> 15, exact for x below 16384
  localparam logic [11:0] DIV10_MUL   = 12'd3277;
  localparam int          DIV10_SHIFT = 15;

  localparam int TABLE_MAX = 16;
  localparam int TABLE_IDX_W = $clog2(TABLE_MAX);

  typedef logic signed [4:0] tdiff_t;

  localparam tdiff_t TABLE_DIFF [TABLE_MAX] = '{
    -5'sd4, -5'sd3, -5'sd2, -5'sd1, 5'sd0, 5'sd1, 5'sd2, 5'sd3,
    5'sd4, 5'sd5, 5'sd6, 5'sd7, 5'sd8, 5'sd9, 5'sd10, 5'sd11
  };

  localparam logic [6:0] TABLE_DUTY [TABLE_MAX] = '{
    7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd45, 7'd65, 7'd90,
    7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
  };

endpackage

FILE: src/fsmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Fan speed mode controller: configuration registers
// Write-only register file, indexed write with enable.
// ----------------------------------------------------------------------------
module fsmc_cfg_regs
  import fsmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CONTROL_MODE:     cfg_nxt.control_mode     = cfg_wdata[1:0];
        CFG_SMOOTH_ENABLE:    cfg_nxt.smooth_enable    = cfg_wdata[0];
        CFG_RPM_DEAD_BAND:    cfg_nxt.rpm_dead_band    = cfg_wdata[15:0];
        CFG_MANUAL_DUTY_STEP: cfg_nxt.manual_duty_step = cfg_wdata[6:0];
        CFG_RPM_TARGET_STEP:  cfg_nxt.rpm_target_step  = cfg_wdata[15:0];
        CFG_TEMP_TARGET_STEP: cfg_nxt.temp_target_step = cfg_wdata[7:0];
        CFG_RPM_TARGET_MAX:   cfg_nxt.rpm_target_max   = cfg_wdata[15:0];
        CFG_TEMP_TARGET_MAX:  cfg_nxt.temp_target_max  = cfg_wdata[7:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_mode     <= MODE_MANUAL;
      cfg_r.smooth_enable    <= 1'b0;
      cfg_r.rpm_dead_band    <= RST_RPM_DEAD_BAND;
      cfg_r.manual_duty_step <= RST_MANUAL_DUTY_STEP;
      cfg_r.rpm_target_step  <= RST_RPM_TARGET_STEP;
      cfg_r.temp_target_step <= RST_TEMP_TARGET_STEP;
      cfg_r.rpm_target_max   <= RST_RPM_TARGET_MAX;
      cfg_r.temp_target_max  <= RST_TEMP_TARGET_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/fsmc_in_stage.sv
// ----------------------------------------------------------------------------
// Fan speed mode controller: input register
// Captures one input transaction and unpacks it for the core.
// ----------------------------------------------------------------------------
module fsmc_in_stage
  import fsmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [2:0]            in_tuser,
  input  logic                  advance,
  output logic                  item_valid,
  output item_t                 item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;
  assign valid_nxt = take || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.func          <= in_tuser;
      item_r.power_on      <= in_tdata[0];
      item_r.rpm_measured  <= in_tdata[16:1];
      item_r.temp_measured <= $signed(in_tdata[25:17]);
      item_r.set_value     <= $signed(in_tdata[42:26]);
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: src/fsmc_core.sv
// ----------------------------------------------------------------------------
// Fan speed mode controller: control core
// Holds duty, targets and smoothed temperature; one item per cycle with advance.
// ----------------------------------------------------------------------------
`include "fan_speed_mode_controller_defines.svh"

module fsmc_core
  import fsmc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 9
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    advance,
  input  item_t   item,
  output result_t res
);

  localparam int LAST = TABLE_ENTRIES - 1;

  logic [6:0]        duty_r,  duty_nxt;
  logic [15:0]       rpm_goal_r, rpm_goal_nxt;
  logic [7:0]        temp_goal_r, temp_goal_nxt;
  logic signed [8:0] tf_r, tf_nxt;

  mode_t mode;
  logic  stall;
  logic  tick_on;

  // manual and target steps
  logic [7:0]  duty_sum;
  logic [6:0]  duty_up, duty_dn;
  logic [16:0] rpm_sum;
  logic [15:0] rpm_up, rpm_dn;
  logic [8:0]  temp_sum;
  logic [7:0]  temp_up, temp_dn;
  logic [15:0] rpm_set;
  logic [7:0]  temp_set;

  // rpm regulation
  logic signed [16:0] rpm_err;
  logic [15:0]        err_mag;
  logic [2:0]         reg_step;
  logic [6:0]         duty_reg_up, duty_reg_dn, duty_rpm;

  // thermal table
  logic signed [12:0] acc;
  logic [11:0]        acc_mag;
  logic [23:0]        prod;
  logic [8:0]         quo;
  logic signed [8:0]  tf_smooth, tf_tick;
  logic signed [9:0]  tdelta;
  logic [TABLE_IDX_W-1:0] tidx;

  assign mode    = mode_t'(cfg.control_mode);
  assign tick_on = (func_t'(item.func) == FUNC_TICK) && item.power_on;

  always_comb begin
    duty_sum = {1'b0, duty_r} + {1'b0, cfg.manual_duty_step};
    duty_up  = (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_sum[6:0];
    duty_dn  = (cfg.manual_duty_step >= duty_r) ? 7'd0 : duty_r - cfg.manual_duty_step;

    rpm_sum = {1'b0, rpm_goal_r} + {1'b0, cfg.rpm_target_step};
    rpm_up  = (rpm_sum > {1'b0, cfg.rpm_target_max}) ? cfg.rpm_target_max : rpm_sum[15:0];
    rpm_dn  = (cfg.rpm_target_step >= rpm_goal_r) ? 16'd0
                                                  : rpm_goal_r - cfg.rpm_target_step;

    temp_sum = {1'b0, temp_goal_r} + {1'b0, cfg.temp_target_step};
    temp_up  = (temp_sum > {1'b0, cfg.temp_target_max}) ? cfg.temp_target_max
                                                         : temp_sum[7:0];
    temp_dn  = (cfg.temp_target_step >= temp_goal_r) ? 8'd0
                                                      : temp_goal_r - cfg.temp_target_step;

    if (item.set_value > $signed({1'b0, cfg.rpm_target_max})) begin
      rpm_set = cfg.rpm_target_max;
    end else if (item.set_value < 0) begin
      rpm_set = 16'd0;
    end else begin
      rpm_set = item.set_value[15:0];
    end

    if (item.set_value > $signed({9'd0, cfg.temp_target_max})) begin
      temp_set = cfg.temp_target_max;
    end else if (item.set_value < 0) begin
      temp_set = 8'd0;
    end else begin
      temp_set = item.set_value[7:0];
    end
  end

  // rpm regulation
  always_comb begin
    rpm_err = $signed({1'b0, rpm_goal_r}) - $signed({1'b0, item.rpm_measured});
    err_mag = rpm_err[16] ? 16'(-rpm_err) : rpm_err[15:0];
    priority if (err_mag > ERR_STEP5) reg_step = 3'd5;
    else if (err_mag > ERR_STEP4)     reg_step = 3'd4;
    else if (err_mag > ERR_STEP3)     reg_step = 3'd3;
    else if (err_mag > ERR_STEP2)     reg_step = 3'd2;
    else                              reg_step = 3'd1;
    duty_reg_up = duty_r + {4'd0, reg_step};
    if (duty_reg_up > DUTY_MAX) duty_reg_up = DUTY_MAX;
    duty_reg_dn = ({4'd0, reg_step} >= duty_r) ? 7'd0 : duty_r - {4'd0, reg_step};
    if (err_mag <= cfg.rpm_dead_band) begin
      duty_rpm = duty_r;
    end else if (!rpm_err[16]) begin
      duty_rpm = duty_reg_up;
    end else begin
      duty_rpm = duty_reg_dn;
    end
  end

  assign stall = tick_on && (mode == MODE_RPM) && (item.rpm_measured == 16'd0)
                 && (duty_r == DUTY_MAX);

  // thermal: (3*old + 7*new) / 10 toward zero, then table search
  always_comb begin
    acc = ($signed({{4{tf_r[8]}}, tf_r}) <<< 1) + $signed({{4{tf_r[8]}}, tf_r})
        + ($signed({{4{item.temp_measured[8]}}, item.temp_measured}) <<< 3)
        - $signed({{4{item.temp_measured[8]}}, item.temp_measured});
    acc_mag   = acc[12] ? 12'(-acc) : acc[11:0];
    prod      = {12'd0, acc_mag} * {12'd0, DIV10_MUL};
    quo       = prod[DIV10_SHIFT+8:DIV10_SHIFT];
    tf_smooth = acc[12] ? -$signed(quo) : $signed(quo);
    tf_tick   = cfg.smooth_enable ? tf_smooth : item.temp_measured;
    tdelta    = $signed({tf_tick[8], tf_tick}) - $signed({2'b00, temp_goal_r});
    tidx      = TABLE_IDX_W'(LAST);
    for (int i = LAST - 1; i >= 0; i--) begin
      if (tdelta <= $signed({{5{TABLE_DIFF[i][4]}}, TABLE_DIFF[i]})) begin
        tidx = TABLE_IDX_W'(i);
      end
    end
  end

  always_comb begin
    duty_nxt      = duty_r;
    rpm_goal_nxt  = rpm_goal_r;
    temp_goal_nxt = temp_goal_r;
    tf_nxt        = tf_r;
    unique case (func_t'(item.func))
      FUNC_TICK: begin
        if (item.power_on) begin
          if (mode == MODE_RPM) begin
            if (!stall) duty_nxt = duty_rpm;
          end else if (mode == MODE_THERMAL) begin
            tf_nxt   = tf_tick;
            duty_nxt = TABLE_DUTY[tidx];
          end
        end
      end
      FUNC_UP: begin
        unique case (mode)
          MODE_MANUAL:  duty_nxt      = duty_up;
          MODE_RPM:     rpm_goal_nxt  = rpm_up;
          MODE_THERMAL: temp_goal_nxt = temp_up;
          MODE_NONE:    duty_nxt      = duty_r;
          default:      duty_nxt      = duty_r;
        endcase
      end
      FUNC_DOWN: begin
        unique case (mode)
          MODE_MANUAL:  duty_nxt      = duty_dn;
          MODE_RPM:     rpm_goal_nxt  = rpm_dn;
          MODE_THERMAL: temp_goal_nxt = temp_dn;
          MODE_NONE:    duty_nxt      = duty_r;
          default:      duty_nxt      = duty_r;
        endcase
      end
      FUNC_SET_RPM:  rpm_goal_nxt  = rpm_set;
      FUNC_SET_TEMP: temp_goal_nxt = temp_set;
      default:       duty_nxt      = duty_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r      <= 7'd0;
      rpm_goal_r  <= RST_RPM_GOAL;
      temp_goal_r <= RST_TEMP_GOAL;
      tf_r        <= 9'sd0;
    end else if (advance) begin
      duty_r      <= duty_nxt;
      rpm_goal_r  <= rpm_goal_nxt;
      temp_goal_r <= temp_goal_nxt;
      tf_r        <= tf_nxt;
    end
  end

  always_comb begin
    res.duty_percent    = duty_nxt;
    res.rpm_target_now  = rpm_goal_nxt;
    res.temp_target_now = temp_goal_nxt;
    res.temp_smoothed   = tf_nxt;
    res.stalled         = stall;
    res.fan_active      = (duty_nxt != 7'd0);
  end

  `FSMC_ASSERT_IMP(a_duty_range, clk, rst_n, 1'b1, duty_r <= DUTY_MAX)
  `FSMC_ASSERT_NXT(a_stall_holds, clk, rst_n, advance && stall, duty_r == $past(duty_r))
  `FSMC_ASSERT_NXT(a_set_rpm_sat, clk, rst_n,
                   advance && (item.func == FUNC_SET_RPM),
                   rpm_goal_r <= $past(cfg.rpm_target_max))
  `FSMC_ASSERT_NXT(a_filter_quiet, clk, rst_n,
                   !(advance && tick_on && (mode == MODE_THERMAL)), $stable(tf_r))

endmodule

FILE: src/fsmc_out_stage.sv
// ----------------------------------------------------------------------------
// Fan speed mode controller: result register
// Holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module fsmc_out_stage
  import fsmc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  result_t                res,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;

  assign valid_nxt = advance || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= {6'd0, res.fan_active, res.stalled, res.temp_smoothed,
                 res.temp_target_now, res.rpm_target_now, res.duty_percent};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

FILE: src/fan_speed_mode_controller.sv
// Path: input register, then core logic, then the result register.
// Throughput: one transaction per cycle unless out_tready holds it off; duty,
//   targets and filter update in the core between the input and result stages.
// Reset (rst_n low, synchronous): both stages empty, registers to defaults,
//   duty 0, rpm target 2000, temperature target 45, filter 0.
// ----------------------------------------------------------------------------
// Fan speed mode controller
// Fan duty regulation by manual steps, rpm error or thermal table.
// ----------------------------------------------------------------------------
module fan_speed_mode_controller
  import fsmc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // power_on[0], rpm_measured[16:1], temp_measured[25:17], set_value[42:26]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [2:0]             in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // duty_percent[6:0], rpm_target_now[22:7], temp_target_now[30:23],
  // temp_smoothed[39:31], stalled[40], fan_active[41]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    item_valid;
  logic    advance;

  assign advance = item_valid && (!out_tvalid || out_tready);

  fsmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fsmc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  fsmc_core #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  fsmc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
